>>> src/kvt_pkg.sv
// Shared types and constants for the key-value table.
package kvt_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int KIND_W  = 2;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_REMOVE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    // operation walking down the row of cells
    typedef struct packed {
        logic                  active;
        t_kind                 kind;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] wval;
        logic                  hit;
        logic                  free_seen;
        logic [VALUE_BITS-1:0] rval;
    } t_tok;

    // end-of-row commit broadcast
    typedef struct packed {
        logic strobe;
        logic take;
    } t_commit;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] read_value;
        logic               refused;
    } t_result;

endpackage

>>> src/kvt_req_if.sv
// Request channel: operation beats into the table.
interface kvt_req_if;
    import kvt_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] write_value;

    modport source (output valid, output kind, output key, output write_value, input ready);
    modport sink   (input valid, input kind, input key, input write_value, output ready);
endinterface

>>> src/kvt_rsp_if.sv
// Response channel: result beats out of the table.
interface kvt_rsp_if;
    import kvt_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               refused;

    modport source (output valid, output hit, output read_value, output refused, input ready);
    modport sink   (input valid, input hit, input read_value, input refused, output ready);
endinterface

>>> src/kvt_cell.sv
// One table entry: compares the passing operation and forwards it to the next cell.
module kvt_cell
    import kvt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_tok    i_tok,
    input  t_commit i_commit,
    output t_tok    o_tok
);

    logic                  r_valid;
    logic                  r_pend;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    t_tok                  r_tok;
    t_tok                  n_tok;
    logic                  w_match;
    logic                  w_free;

    assign w_match = i_tok.active && r_valid && (r_key == i_tok.key);
    assign w_free  = i_tok.active && !r_valid && !i_tok.free_seen;

    always_comb begin
        n_tok           = i_tok;
        n_tok.hit       = i_tok.hit | w_match;
        n_tok.free_seen = i_tok.free_seen | w_free;
        if (w_match && (i_tok.kind == KIND_LOOKUP)) begin
            n_tok.rval = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend       <= 1'b0;
            r_tok.active <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_commit.strobe) begin
                r_valid <= r_valid | (r_pend & i_commit.take);
                r_pend  <= 1'b0;
            end else if (i_tok.active) begin
                if (w_match && (i_tok.kind == KIND_INSERT)) begin
                    r_value <= i_tok.wval;
                end
                if (w_match && (i_tok.kind == KIND_REMOVE)) begin
                    r_valid <= 1'b0;
                end
                if (w_free && (i_tok.kind == KIND_INSERT)) begin
                    r_key   <= i_tok.key;
                    r_value <= i_tok.wval;
                    r_pend  <= 1'b1;
                end
            end
        end
    end

    assign o_tok = r_tok;

endmodule

>>> src/kvt_ctrl.sv
// Sequencer: admits one operation, commits at the end of the row, holds the result beat.
module kvt_ctrl
    import kvt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_tok    i_tok_last,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output t_commit o_commit,
    output logic    o_out_valid,
    output t_result o_result
);

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result r_hold;
    t_result w_res;
    logic    w_out_free;
    logic    w_load_res;
    logic    w_load_hold;
    logic    w_store_hold;
    logic    w_kind_known;

    assign w_out_free = !r_out_valid || i_out_ready;

    // an unused kind never reports a hit
    assign w_kind_known = (i_tok_last.kind == KIND_INSERT) || (i_tok_last.kind == KIND_LOOKUP)
                          || (i_tok_last.kind == KIND_REMOVE);

    always_comb begin
        w_res.hit        = i_tok_last.hit && w_kind_known;
        w_res.read_value = VALUE_W'(i_tok_last.rval);
        w_res.refused    = (i_tok_last.kind == KIND_INSERT) && !i_tok_last.hit
                           && !i_tok_last.free_seen;
        o_commit.strobe  = i_tok_last.active;
        o_commit.take    = (i_tok_last.kind == KIND_INSERT) && !i_tok_last.hit
                           && i_tok_last.free_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_res) begin
            r_out <= w_res;
        end else if (w_load_hold) begin
            r_out <= r_hold;
        end
        if (w_store_hold) begin
            r_hold <= w_res;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_load_res   = 1'b0;
        w_load_hold  = 1'b0;
        w_store_hold = 1'b0;
        o_in_ready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_accept) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_tok_last.active) begin
                    if (w_out_free) begin
                        w_load_res = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        w_store_hold = 1'b1;
                        n_state      = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    w_load_hold = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || w_load_res || w_load_hold;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

>>> src/key_value_table_top.sv
// An operation walks the row of cells, one cell per cycle, and commits a new entry
//   as it leaves the last cell; a new request is taken only after the previous result
//   has been loaded into the output register.
// A finished response waits in the output register while the next request is taken.
// Reset (synchronous, active low) empties the table at once and drops any beat in flight.
module key_value_table_top
    import kvt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    kvt_req_if.sink      i_req,
    kvt_rsp_if.source    o_rsp
);

    t_tok    w_tok [ENTRIES+1];
    t_commit w_commit;
    t_result w_result;
    logic    w_accept;
    logic    w_in_ready;
    logic    w_out_valid;

    assign w_accept = i_req.valid && w_in_ready;

    always_comb begin
        w_tok[0].active    = w_accept;
        w_tok[0].kind      = t_kind'(i_req.kind);
        w_tok[0].key       = KEY_BITS'(i_req.key);
        w_tok[0].wval      = VALUE_BITS'(i_req.write_value);
        w_tok[0].hit       = 1'b0;
        w_tok[0].free_seen = 1'b0;
        w_tok[0].rval      = '0;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kvt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .i_commit (w_commit),
            .o_tok    (w_tok[g+1])
        );
    end

    kvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_tok_last  (w_tok[ENTRIES]),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (w_in_ready),
        .o_commit    (w_commit),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    assign i_req.ready      = w_in_ready;
    assign o_rsp.valid      = w_out_valid;
    assign o_rsp.hit        = w_result.hit;
    assign o_rsp.read_value = w_result.read_value;
    assign o_rsp.refused    = w_result.refused;

endmodule

>>> src/kvt_checker.sv
// Port-level checks for the key-value table, bound to the top level.
module kvt_checker
    import kvt_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic               i_rsp_hit,
    input logic [VALUE_W-1:0] i_rsp_read_value,
    input logic               i_rsp_refused
);

    // a refused insert never saw its key
    a_refused_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_refused) |-> !i_rsp_hit)
        else $error("refused beat with hit set");

    // a nonzero read value only comes from a hit
    a_value_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_read_value != '0)) |-> i_rsp_hit)
        else $error("read value without hit");

    // one operation in flight: request side closes after a beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while busy");

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_hit)
            && $stable(i_rsp_read_value) && $stable(i_rsp_refused)))
        else $error("stalled response beat changed");

endmodule

bind key_value_table_top kvt_checker u_kvt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_hit        (o_rsp.hit),
    .i_rsp_read_value (o_rsp.read_value),
    .i_rsp_refused    (o_rsp.refused)
);

>>> test/tb_key_value_table_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for key_value_table_top: shadow table, random traffic, backpressure.
module tb_key_value_table_top;
    import kvt_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int POOL_SIZE = 24;
    localparam int DRAIN_CYCLES = 3 * (ENTRIES + 1);

    // Shadow copy of the table; predicts one result beat per request beat.
    class table_mirror;
        bit                    slot_used[ENTRIES];
        logic [KEY_BITS-1:0]   slot_key[ENTRIES];
        logic [VALUE_BITS-1:0] slot_value[ENTRIES];
        t_result               expected_results[$];
        int                    failures;

        function void apply_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                               logic [VALUE_W-1:0] wval);
            int      match;
            int      free_slot;
            t_result res;
            match     = -1;
            free_slot = -1;
            res       = '0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_used[i]) begin
                    if (match < 0 && slot_key[i] == key[KEY_BITS-1:0]) begin
                        match = i;
                    end
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (kind == KIND_INSERT) begin
                if (match >= 0) begin
                    res.hit = 1'b1;
                    slot_value[match] = wval[VALUE_BITS-1:0];
                end else if (free_slot >= 0) begin
                    slot_used[free_slot]  = 1'b1;
                    slot_key[free_slot]   = key[KEY_BITS-1:0];
                    slot_value[free_slot] = wval[VALUE_BITS-1:0];
                end else begin
                    res.refused = 1'b1;
                end
            end else if (kind == KIND_LOOKUP) begin
                if (match >= 0) begin
                    res.hit        = 1'b1;
                    res.read_value = slot_value[match];
                end
            end else if (kind == KIND_REMOVE) begin
                if (match >= 0) begin
                    res.hit = 1'b1;
                    slot_used[match] = 1'b0;
                end
            end
            expected_results.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("ERROR: result beat with none pending: hit=%0b value=%h refused=%0b",
                             got.hit, got.read_value, got.refused);
                end
                return;
            end
            want = expected_results.pop_front();
            if (got.hit !== want.hit || got.read_value !== want.read_value ||
                got.refused !== want.refused) begin
                failures++;
                if (failures <= 10) begin
                    $display("ERROR: exp hit=%0b value=%h refused=%0b, got hit=%0b value=%h refused=%0b",
                             want.hit, want.read_value, want.refused,
                             got.hit, got.read_value, got.refused);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    kvt_req_if req_bus();
    kvt_rsp_if rsp_bus();

    key_value_table_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    table_mirror      mirror;
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    bit               quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic bit take_break();
        return !quiet && ($urandom_range(0, 99) < 8);
    endfunction

    task automatic send_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                           logic [VALUE_W-1:0] wval);
        while (take_break()) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.kind        <= kind;
        req_bus.key         <= key;
        req_bus.write_value <= wval;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        mirror.apply_op(kind, key, wval);
    endtask

    task automatic directed_ops();
        send_op(KIND_LOOKUP, '0, '0);
        send_op(KIND_REMOVE, '0, '1);
        send_op(KIND_UNUSED, '1, '1);
        send_op(KIND_INSERT, '0, '0);
        send_op(KIND_INSERT, '1, '1);
        send_op(KIND_LOOKUP, '1, '0);
        send_op(KIND_INSERT, '0, '1);
        send_op(KIND_LOOKUP, '0, '0);
        for (int i = 0; i < ENTRIES - 2; i++) begin
            send_op(KIND_INSERT, key_pool[i], $urandom);
        end
        // table is full now
        send_op(KIND_INSERT, key_pool[ENTRIES-2], 32'h1234_5678);
        send_op(KIND_INSERT, '0, 32'h0BAD_F00D);
        send_op(KIND_LOOKUP, '0, '1);
        send_op(KIND_REMOVE, '1, '0);
        send_op(KIND_LOOKUP, '1, '0);
        send_op(KIND_INSERT, key_pool[ENTRIES-2], 32'h8765_4321);
        send_op(KIND_UNUSED, key_pool[ENTRIES-2], '0);
    endtask

    task automatic random_ops(int count, int w_ins, int w_look, int w_rem);
        int                 roll;
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] wval;
        repeat (count) begin
            if ($urandom_range(0, 99) < 5) begin
                key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
            end
            roll = $urandom_range(0, 99);
            if (roll < w_ins) begin
                kind = KIND_INSERT;
            end else if (roll < w_ins + w_look) begin
                kind = KIND_LOOKUP;
            end else if (roll < w_ins + w_look + w_rem) begin
                kind = KIND_REMOVE;
            end else begin
                kind = KIND_UNUSED;
            end
            if ($urandom_range(0, 99) < 4) begin
                key = $urandom;
            end else begin
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            case ($urandom_range(0, 9))
                0: begin
                    wval = '0;
                end
                1: begin
                    wval = '1;
                end
                default: begin
                    wval = $urandom;
                end
            endcase
            send_op(kind, key, wval);
        end
    endtask

    // result side: sample at the edge, then pick next ready
    initial begin
        t_result beat;
        rsp_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (rsp_bus.valid && rsp_bus.ready) begin
                beat.hit        = rsp_bus.hit;
                beat.read_value = rsp_bus.read_value;
                beat.refused    = rsp_bus.refused;
                mirror.check_result(beat);
            end
            rsp_bus.ready <= !take_break();
        end
    end

    initial begin
        mirror = new;
        quiet  = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        i_rst_n             <= 1'b0;
        req_bus.valid       <= 1'b0;
        req_bus.kind        <= KIND_INSERT;
        req_bus.key         <= '0;
        req_bus.write_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_ops();
        random_ops(150, 48, 30, 20);
        quiet = 1'b1;
        random_ops(150, 35, 33, 30);
        quiet = 1'b0;
        random_ops(150, 25, 35, 38);
        req_bus.valid <= 1'b0;

        while (mirror.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mirror.failures == 0 && mirror.expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
